// File: sv/lfsc_pkg.sv
// ----------------------------------------------------------------------------
// lfsc_pkg
// Shared types, widths and codes of the line-follow steering controller.
// ----------------------------------------------------------------------------
`default_nettype none

package lfsc_pkg;

    // Defaults for the top-level parameters
    localparam int CAL_SAMPLES_DEF = 10;
    localparam int SAMPLE_BITS_DEF = 16;

    // Fixed widths (sized for the widest sample setting)
    localparam int IN_W    = 16;
    localparam int CNT_W   = 4;
    localparam int TOT_W   = 18;
    localparam int DIFF_W  = 19;
    localparam int SUM_W   = 22;
    localparam int PROD_W  = 30;
    localparam int DVD_W   = 28;
    localparam int DVS_W   = 18;
    localparam int STEER_W = 10;
    localparam int PULSE_W = 15;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 18;

    localparam int QDEPTH  = 2;

    localparam logic [8:0] STEER_CEIL = 9'd500;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_DEAD_BAND    = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_GAIN         = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_STEER_LIMIT  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_OFF_COURSE   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_PULSE_CENTER = 3'd4;

    // Configuration reset values
    localparam logic [15:0] RST_DEAD_BAND    = 16'd10;
    localparam logic [9:0]  RST_GAIN         = 10'd100;
    localparam logic [8:0]  RST_STEER_LIMIT  = 9'd500;
    localparam logic [17:0] RST_OFF_COURSE   = 18'd100;
    localparam logic [13:0] RST_PULSE_CENTER = 14'd1500;

    // Item kinds decided by the front end
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_CAL      = 2'd0;
    localparam t_kind KIND_CAL_LAST = 2'd1;
    localparam t_kind KIND_RUN      = 2'd2;

    // Direction codes
    typedef logic [1:0] t_dir;
    localparam t_dir DIR_STRAIGHT = 2'd0;
    localparam t_dir DIR_LEFT     = 2'd1;
    localparam t_dir DIR_RIGHT    = 2'd2;

    typedef struct packed {
        t_kind                     kind;
        logic [TOT_W-1:0]          total;
        logic signed [DIFF_W-1:0]  diff;
    } t_item;

    typedef struct packed {
        logic [15:0] dead_band;
        logic [9:0]  gain;
        logic [8:0]  steer_limit;
        logic [17:0] off_course_total;
        logic [13:0] pulse_center;
    } t_cfg;

    typedef struct packed {
        logic signed [STEER_W-1:0] steer_value;
        logic [PULSE_W-1:0]        pulse_width;
        t_dir                      direction;
        logic                      calibrating;
        logic                      range_error;
    } t_result;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// File: sv/lfsc_front.sv
// ----------------------------------------------------------------------------
// lfsc_front
// Accepts sensor readings, forms total and left/right difference, and tags
// each reading as calibration, last calibration or steering.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsc_front import lfsc_pkg::*; #(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [4*IN_W-1:0] i_s_tdata,
    input  wire logic              i_full,
    output logic                   o_push,
    output t_item                  o_item
);

    localparam logic [IN_W-1:0]  SMASK   = IN_W'((33'd1 << SAMPLE_BITS) - 33'd1);
    localparam logic [CNT_W-1:0] CAL_N   = CNT_W'(CAL_SAMPLES);
    localparam logic [CNT_W-1:0] CAL_TOP = CNT_W'(CAL_SAMPLES - 1);

    logic [CNT_W-1:0]  r_calib_count;
    logic [IN_W-1:0]   w_a, w_b, w_c, w_d;
    logic [DIFF_W-1:0] w_diff;

    assign w_a = i_s_tdata[IN_W-1:0]        & SMASK;
    assign w_b = i_s_tdata[2*IN_W-1:IN_W]   & SMASK;
    assign w_c = i_s_tdata[3*IN_W-1:2*IN_W] & SMASK;
    assign w_d = i_s_tdata[4*IN_W-1:3*IN_W] & SMASK;

    assign o_s_tready = !i_full;
    assign o_push     = i_s_tvalid && !i_full;

    // two's complement wrap at DIFF_W gives the signed difference
    assign w_diff = DIFF_W'(w_c) + DIFF_W'(w_d) - DIFF_W'(w_a) - DIFF_W'(w_b);

    always_comb begin
        o_item.total = TOT_W'(w_a) + TOT_W'(w_b) + TOT_W'(w_c) + TOT_W'(w_d);
        o_item.diff  = $signed(w_diff);
        if (r_calib_count < CAL_N) begin
            o_item.kind = (r_calib_count == CAL_TOP) ? KIND_CAL_LAST : KIND_CAL;
        end else begin
            o_item.kind = KIND_RUN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_calib_count <= '0;
        end else if (o_push && (r_calib_count < CAL_N)) begin
            r_calib_count <= r_calib_count + CNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// File: sv/lfsc_queue.sv
// ----------------------------------------------------------------------------
// lfsc_queue
// Short FIFO of classified requests between the front and back ends.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsc_queue import lfsc_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_push,
    input  wire t_item i_item,
    output logic       o_full,
    input  wire logic  i_pop,
    output logic       o_valid,
    output t_item      o_item
);

    localparam int PTR_W = $clog2(QDEPTH);
    localparam int CNT_W_Q = $clog2(QDEPTH + 1);

    t_item              r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr;
    logic [PTR_W-1:0]   r_rd;
    logic [CNT_W_Q-1:0] r_cnt;

    assign o_full  = (r_cnt == CNT_W_Q'(QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + CNT_W_Q'(1);
                2'b01:   r_cnt <= r_cnt - CNT_W_Q'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

`default_nettype wire

// File: sv/lfsc_div.sv
// ----------------------------------------------------------------------------
// lfsc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsc_div import lfsc_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_div_req i_req,
    output t_div_rsp      o_rsp
);

    localparam int STEP_W = $clog2(DVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_cnt;
    logic [DVS_W-1:0]  r_rem;
    logic [DVD_W-1:0]  r_quo;
    logic [DVS_W-1:0]  r_dvs;
    logic [DVS_W:0]    w_shift;
    logic [DVS_W+1:0]  w_trial;
    logic              w_ge;

    assign w_shift = {r_rem, r_quo[DVD_W-1]};
    assign w_trial = {1'b0, w_shift} - {2'b00, r_dvs};
    assign w_ge    = !w_trial[DVS_W+1];

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - STEP_W'(1);
                if (r_cnt == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_dvs <= i_req.divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_trial[DVS_W-1:0] : w_shift[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], w_ge};
        end
    end

endmodule

`default_nettype wire

// File: sv/lfsc_back.sv
// ----------------------------------------------------------------------------
// lfsc_back
// Executes queued requests: calibration sum and average, direction with dead
// band, proportional magnitude through the serial divider, clamp, output.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsc_back import lfsc_pkg::*; #(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_q_valid,
    input  wire t_item    i_q_item,
    output logic          o_pop,
    output t_div_req      o_div_req,
    input  wire t_div_rsp i_div_rsp,
    output logic          o_m_tvalid,
    input  wire logic     i_m_tready,
    output t_result       o_res
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EVAL  = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    // floor(sum / CAL_SAMPLES) by reciprocal multiply, exact for any sum
    // below 2**SUM_W while CAL_SAMPLES stays at or below 16
    localparam int REC_SH = SUM_W + 4;
    localparam int AVG_W  = SUM_W + REC_SH + 1;
    localparam logic [REC_SH:0] REC_M =
        (REC_SH + 1)'(((64'd1 << REC_SH) + 64'(CAL_SAMPLES) - 64'd1) / 64'(CAL_SAMPLES));

    logic [2:0]                r_state;
    t_item                     r_ent;
    logic [SUM_W-1:0]          r_sum;
    logic [TOT_W-1:0]          r_ref;
    logic signed [PROD_W-1:0]  r_prod;
    logic [DVS_W-1:0]          r_span;
    t_dir                      r_dir;
    t_result                   r_res;
    t_result                   r_out;
    logic                      r_out_valid;

    logic [TOT_W:0]            w_span;
    logic                      w_span_ok;
    logic signed [TOT_W:0]     w_err;
    logic signed [PROD_W-1:0]  w_prod;
    logic signed [DIFF_W:0]    w_diff;
    logic signed [DIFF_W:0]    w_band;
    t_dir                      w_dir;
    logic [DVD_W-1:0]          w_abs;
    logic [8:0]                w_lim;
    logic [8:0]                w_magc;
    logic signed [STEER_W-1:0] w_mag;
    logic signed [STEER_W-1:0] w_steer;
    logic signed [PULSE_W:0]   w_pulse;
    logic [PULSE_W-1:0]        w_pulse_sat;
    logic                      w_out_free;
    logic [AVG_W-1:0]          w_avg_full;

    assign o_pop      = (r_state == S_IDLE) && i_q_valid;
    assign w_out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid = r_out_valid;
    assign o_res      = r_out;

    // span = reference - off-course total; must be strictly positive
    assign w_span    = {1'b0, r_ref} - {1'b0, i_cfg.off_course_total};
    assign w_span_ok = !w_span[TOT_W] && (w_span != '0);
    assign w_err     = $signed({1'b0, r_ref}) - $signed({1'b0, r_ent.total});
    assign w_prod    = PROD_W'($signed({1'b0, i_cfg.gain}) * w_err);

    assign w_diff = DIFF_W'(r_ent.diff) + (DIFF_W + 1)'(0);
    assign w_band = $signed({4'b0000, i_cfg.dead_band});

    assign w_avg_full = AVG_W'(r_sum) * AVG_W'(REC_M);

    always_comb begin
        if (w_diff > w_band) begin
            w_dir = DIR_LEFT;
        end else if (w_diff < -w_band) begin
            w_dir = DIR_RIGHT;
        end else begin
            w_dir = DIR_STRAIGHT;
        end
    end

    assign w_abs = r_prod[PROD_W-1] ? DVD_W'(-r_prod) : DVD_W'(r_prod);

    // clamp magnitude, then restore sign of the product and apply direction
    assign w_lim  = (i_cfg.steer_limit > STEER_CEIL) ? STEER_CEIL : i_cfg.steer_limit;
    assign w_magc = (i_div_rsp.quotient > DVD_W'(w_lim)) ? w_lim
                                                         : i_div_rsp.quotient[8:0];
    assign w_mag  = r_prod[PROD_W-1] ? -$signed({1'b0, w_magc}) : $signed({1'b0, w_magc});

    always_comb begin
        case (r_dir)
            DIR_LEFT:  w_steer = w_mag;
            DIR_RIGHT: w_steer = -w_mag;
            default:   w_steer = '0;
        endcase
    end

    assign w_pulse = $signed({2'b00, i_cfg.pulse_center})
                   + (PULSE_W + 1)'(r_res.steer_value);
    assign w_pulse_sat = w_pulse[PULSE_W] ? '0 : w_pulse[PULSE_W-1:0];

    always_comb begin
        o_div_req.start    = (r_state == S_START);
        o_div_req.dividend = w_abs;
        o_div_req.divisor  = r_span;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_sum       <= '0;
            r_ref       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_ent.kind == KIND_RUN) begin
                        r_state <= w_span_ok ? S_START : S_DONE;
                    end else begin
                        r_sum   <= r_sum + SUM_W'(r_ent.total);
                        r_state <= (r_ent.kind == KIND_CAL_LAST) ? S_FIN : S_DONE;
                    end
                end
                S_START: begin
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (i_div_rsp.done) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (r_ent.kind == KIND_CAL_LAST) begin
                        r_ref <= w_avg_full[REC_SH +: TOT_W];
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // payload path
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_ent <= i_q_item;
        end
        if (r_state == S_EVAL) begin
            r_dir  <= w_dir;
            r_prod <= w_prod;
            r_span <= w_span[DVS_W-1:0];
            r_res.steer_value <= '0;
            r_res.pulse_width <= '0;
            if (r_ent.kind == KIND_RUN) begin
                r_res.direction   <= w_dir;
                r_res.calibrating <= 1'b0;
                r_res.range_error <= !w_span_ok;
            end else begin
                r_res.direction   <= DIR_STRAIGHT;
                r_res.calibrating <= 1'b1;
                r_res.range_error <= 1'b0;
            end
        end
        if ((r_state == S_FIN) && (r_ent.kind == KIND_RUN)) begin
            r_res.steer_value <= w_steer;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out <= '{steer_value: r_res.steer_value,
                       pulse_width: w_pulse_sat,
                       direction:   r_res.direction,
                       calibrating: r_res.calibrating,
                       range_error: r_res.range_error};
        end
    end

endmodule

`default_nettype wire

// File: sv/line_follow_steering_controller.sv
// A reading passes the queue, then the back-end states EVAL and DONE for a
// calibration or range-error reading, EVAL, FIN and DONE for the last calibration
// reading, and EVAL, START, DIV, FIN and DONE for a steering reading.
// The back end takes one reading at a time, so a steering reading holds the next
// one back while the 28-step restoring divider runs.
// Reset (i_rst_n low, synchronous) restarts calibration and reloads defaults.
// ----------------------------------------------------------------------------
// line_follow_steering_controller
// Proportional line-follow steering with start-up brightness calibration.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follow_steering_controller import lfsc_pkg::*; #(
    parameter int CAL_SAMPLES = CAL_SAMPLES_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    // [15:0] clear_a, [31:16] clear_b, [47:32] clear_c, [63:48] clear_d
    input  wire logic [4*IN_W-1:0] i_s_tdata,
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    // [9:0] steer_value, [24:10] pulse_width, [26:25] direction, [31:27] zero
    output logic [31:0]            o_m_tdata,
    // [0] calibrating, [1] range_error
    output logic [1:0]             o_m_tuser,
    input  wire logic              i_cfg_valid,
    output logic                   o_cfg_ready,
    input  wire logic [CIDX_W-1:0] i_cfg_index,
    input  wire logic [CDAT_W-1:0] i_cfg_data
);

    t_cfg     r_cfg;
    logic     w_push;
    logic     w_full;
    logic     w_pop;
    logic     w_q_valid;
    t_item    w_f_item;
    t_item    w_q_item;
    t_div_req w_div_req;
    t_div_rsp w_div_rsp;
    t_result  w_res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_band        <= RST_DEAD_BAND;
            r_cfg.gain             <= RST_GAIN;
            r_cfg.steer_limit      <= RST_STEER_LIMIT;
            r_cfg.off_course_total <= RST_OFF_COURSE;
            r_cfg.pulse_center     <= RST_PULSE_CENTER;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEAD_BAND:    r_cfg.dead_band        <= i_cfg_data[15:0];
                CFG_GAIN:         r_cfg.gain             <= i_cfg_data[9:0];
                CFG_STEER_LIMIT:  r_cfg.steer_limit      <= i_cfg_data[8:0];
                CFG_OFF_COURSE:   r_cfg.off_course_total <= i_cfg_data[17:0];
                CFG_PULSE_CENTER: r_cfg.pulse_center     <= i_cfg_data[13:0];
                default:          r_cfg                  <= r_cfg;
            endcase
        end
    end

    lfsc_front #(
        .CAL_SAMPLES (CAL_SAMPLES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_item     (w_f_item)
    );

    lfsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_f_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    lfsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_rsp   (w_div_rsp)
    );

    lfsc_back #(
        .CAL_SAMPLES (CAL_SAMPLES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_valid  (w_q_valid),
        .i_q_item   (w_q_item),
        .o_pop      (w_pop),
        .o_div_req  (w_div_req),
        .i_div_rsp  (w_div_rsp),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_res      (w_res)
    );

    assign o_m_tdata = {5'b00000, w_res.direction, w_res.pulse_width, w_res.steer_value};
    assign o_m_tuser = {w_res.range_error, w_res.calibrating};

endmodule

`default_nettype wire

// File: sv/lfsc_checker.sv
// ----------------------------------------------------------------------------
// lfsc_checker
// Port-level checks of the steering controller, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lfsc_checker import lfsc_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              o_m_tvalid,
    input wire logic              i_m_tready,
    input wire logic [31:0]       o_m_tdata,
    input wire logic [1:0]        o_m_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tuser)))
        else $error("result dropped or changed while stalled");

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // calibration result is neutral and never flags a range error
    a_cal_neutral: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |->
            (o_m_tdata[9:0] == 10'd0) && (o_m_tdata[26:25] == DIR_STRAIGHT)
            && !o_m_tuser[1])
        else $error("calibration result not neutral");

    // a nonzero steer needs a direction and a valid range
    a_steer_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (o_m_tdata[9:0] != 10'd0)) |->
            ((o_m_tdata[26:25] == DIR_LEFT) || (o_m_tdata[26:25] == DIR_RIGHT))
            && !o_m_tuser[1])
        else $error("steer without direction or with range error");

    // steer magnitude stays within the ceiling
    a_steer_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |->
            ($signed(o_m_tdata[9:0]) <= 10'sd500) && ($signed(o_m_tdata[9:0]) >= -10'sd500))
        else $error("steer beyond ceiling");

endmodule

bind line_follow_steering_controller lfsc_checker u_lfsc_checker (.*);

`default_nettype wire

// File: tb/line_follow_steering_controller_tb.sv
// ----------------------------------------------------------------------------
// line_follow_steering_controller_tb
// Drives sensor readings and register writes into the steering controller and
// checks every steering command against a cycle-free model or a command given
// in a directed table. The table covers calibration, the dead band, clamping,
// range errors, pulse saturation; random phases with new register settings follow.
// ----------------------------------------------------------------------------

module line_follow_steering_controller_tb;
    import lfsc_pkg::*;

    localparam int CYCLE_LIMIT    = 400000;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 100;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 50;
    localparam int REPORT_CAP     = 100;
    localparam logic [IN_W-1:0] SAMPLE_MASK = IN_W'((64'd1 << SAMPLE_BITS_DEF) - 64'd1);
    localparam logic [CIDX_W-1:0] CFG_FIRST_UNUSED = CFG_PULSE_CENTER + 3'd1;
    localparam logic [CIDX_W-1:0] CFG_LAST_UNUSED  = {CIDX_W{1'b1}};

    typedef struct {
        bit                is_reg;
        logic [CIDX_W-1:0] idx;
        logic [CDAT_W-1:0] val;
        logic [IN_W-1:0]   ca, cb, cc, cd;
        bit                typed;
        t_result           want;
    } t_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_s_tvalid = 1'b0;
    logic              o_s_tready;
    logic [4*IN_W-1:0] i_s_tdata = '0;
    logic              o_m_tvalid;
    logic              i_m_tready = 1'b0;
    logic [31:0]       o_m_tdata;
    logic [1:0]        o_m_tuser;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [CIDX_W-1:0] i_cfg_index = '0;
    logic [CDAT_W-1:0] i_cfg_data = '0;

    // controller model state
    t_cfg              cfg = '{dead_band: RST_DEAD_BAND, gain: RST_GAIN,
                               steer_limit: RST_STEER_LIMIT,
                               off_course_total: RST_OFF_COURSE,
                               pulse_center: RST_PULSE_CENTER};
    logic [CNT_W-1:0]  cal_count = '0;
    logic [SUM_W-1:0]  cal_sum = '0;
    logic [TOT_W-1:0]  bright_ref = '0;

    t_result           pending_cmds [$];
    t_row              plan [$];
    int                err_cnt = 0;
    int                cycles = 0;
    int                idle_pct = 25;
    bit                hold_req = 1'b0;

    line_follow_steering_controller DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_result cmd(input longint steer, input longint pulse,
                                    input t_dir dir, input bit cal, input bit rerr);
        t_result r;
        r.steer_value = steer[STEER_W-1:0];
        r.pulse_width = pulse[PULSE_W-1:0];
        r.direction   = dir;
        r.calibrating = cal;
        r.range_error = rerr;
        return r;
    endfunction

    function automatic t_row reading(input logic [IN_W-1:0] a, b, c, d,
                                     input bit typed = 1'b0, input t_result want = '0);
        t_row r;
        r.is_reg = 1'b0;
        r.idx    = '0;
        r.val    = '0;
        r.ca     = a;
        r.cb     = b;
        r.cc     = c;
        r.cd     = d;
        r.typed  = typed;
        r.want   = want;
        return r;
    endfunction

    function automatic t_row reg_write(input logic [CIDX_W-1:0] idx,
                                       input logic [CDAT_W-1:0] val);
        t_row r;
        r        = reading('0, '0, '0, '0);
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.val    = val;
        return r;
    endfunction

    // Advance calibration or compute the steering command for one reading.
    function automatic t_result steer_predict(input logic [IN_W-1:0] ca, cb, cc, cd);
        longint  a, b, c, d, total, diff, band, span, lim, mag, steer, pulse;
        t_result r;
        a     = ca & SAMPLE_MASK;
        b     = cb & SAMPLE_MASK;
        c     = cc & SAMPLE_MASK;
        d     = cd & SAMPLE_MASK;
        total = a + b + c + d;
        steer = 0;
        r     = '0;
        r.direction = DIR_STRAIGHT;
        if (cal_count < CAL_SAMPLES_DEF) begin
            r.calibrating = 1'b1;
            cal_sum   = SUM_W'(cal_sum + total);
            cal_count = cal_count + 1'b1;
            if (cal_count >= CAL_SAMPLES_DEF)
                bright_ref = TOT_W'(cal_sum / CAL_SAMPLES_DEF);
        end else begin
            diff = (c + d) - (a + b);
            band = longint'(cfg.dead_band);
            span = longint'(bright_ref) - longint'(cfg.off_course_total);
            lim  = longint'(cfg.steer_limit);
            if (lim > longint'(STEER_CEIL))
                lim = longint'(STEER_CEIL);
            if (diff > band)
                r.direction = DIR_LEFT;
            else if (diff < -band)
                r.direction = DIR_RIGHT;
            if (span <= 0) begin
                r.range_error = 1'b1;
            end else begin
                mag = longint'(cfg.gain) * (longint'(bright_ref) - total) / span;
                if (mag > lim)
                    mag = lim;
                if (mag < -lim)
                    mag = -lim;
                if (r.direction == DIR_LEFT)
                    steer = mag;
                else if (r.direction == DIR_RIGHT)
                    steer = -mag;
            end
        end
        pulse = longint'(cfg.pulse_center) + steer;
        if (pulse < 0)
            pulse = 0;
        r.steer_value = steer[STEER_W-1:0];
        r.pulse_width = pulse[PULSE_W-1:0];
        return r;
    endfunction

    task automatic report(input string what, input longint want, input longint seen);
        err_cnt++;
        if (err_cnt <= REPORT_CAP)
            $display("%0t: %s expected %0d got %0d", $time, what, want, seen);
    endtask

    task automatic send_reading(input logic [IN_W-1:0] ca, cb, cc, cd,
                                input bit typed, input t_result want);
        t_result calc;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {cd, cc, cb, ca};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        calc = steer_predict(ca, cb, cc, cd);
        pending_cmds.push_back(typed ? want : calc);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Drop the stream and wait for every outstanding command.
    task automatic drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_cmds.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CDAT_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            CFG_DEAD_BAND:    cfg.dead_band        = val[15:0];
            CFG_GAIN:         cfg.gain             = val[9:0];
            CFG_STEER_LIMIT:  cfg.steer_limit      = val[8:0];
            CFG_OFF_COURSE:   cfg.off_course_total = val[17:0];
            CFG_PULSE_CENTER: cfg.pulse_center     = val[13:0];
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic shuffle_settings();
        logic [CDAT_W-1:0] v;
        case ($urandom_range(0, 3))
            0:       v = '0;
            1:       v = CDAT_W'(16'hFFFF);
            2:       v = CDAT_W'($urandom_range(0, 300));
            default: v = CDAT_W'($urandom_range(0, 65535));
        endcase
        write_reg(CFG_DEAD_BAND, v);
        case ($urandom_range(0, 3))
            0:       v = '0;
            1:       v = CDAT_W'(1023);
            2:       v = CDAT_W'($urandom);     // upper bits get masked
            default: v = CDAT_W'($urandom_range(0, 1023));
        endcase
        write_reg(CFG_GAIN, v);
        case ($urandom_range(0, 3))
            0:       v = '0;
            1:       v = CDAT_W'(STEER_CEIL);
            2:       v = CDAT_W'($urandom_range(501, 511));
            default: v = CDAT_W'($urandom_range(0, 500));
        endcase
        write_reg(CFG_STEER_LIMIT, v);
        // mostly keep the span positive so the divider path gets exercised
        case ($urandom_range(0, 7))
            0:       v = '0;
            1:       v = {CDAT_W{1'b1}};
            2:       v = CDAT_W'(bright_ref);
            default: v = CDAT_W'($urandom_range(0, int'(bright_ref) - 1));
        endcase
        write_reg(CFG_OFF_COURSE, v);
        case ($urandom_range(0, 5))
            0:       v = CDAT_W'(500);
            1:       v = CDAT_W'(16383);
            2:       v = CDAT_W'($urandom_range(0, 499));
            default: v = CDAT_W'($urandom_range(500, 16383));
        endcase
        write_reg(CFG_PULSE_CENTER, v);
        if ($urandom_range(0, 3) == 0)
            write_reg(CIDX_W'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                      CDAT_W'($urandom));
    endtask

    function automatic logic [IN_W-1:0] pick_clear();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3, 4: return IN_W'($urandom_range(0, 30000));
            default: return IN_W'($urandom);
        endcase
    endfunction

    // Receiver: random short stalls, plus one long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
                i_m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want, got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.steer_value = o_m_tdata[STEER_W-1:0];
            got.pulse_width = o_m_tdata[STEER_W +: PULSE_W];
            got.direction   = o_m_tdata[STEER_W+PULSE_W +: 2];
            got.calibrating = o_m_tuser[0];
            got.range_error = o_m_tuser[1];
            if (pending_cmds.size() == 0) begin
                report("unexpected command, pulse_width", -1, got.pulse_width);
            end else begin
                want = pending_cmds.pop_front();
                if (got.steer_value != want.steer_value)
                    report("steer_value", want.steer_value, got.steer_value);
                if (got.pulse_width != want.pulse_width)
                    report("pulse_width", want.pulse_width, got.pulse_width);
                if (got.direction != want.direction)
                    report("direction", want.direction, got.direction);
                if (got.calibrating != want.calibrating)
                    report("calibrating", want.calibrating, got.calibrating);
                if (got.range_error != want.range_error)
                    report("range_error", want.range_error, got.range_error);
                if (o_m_tdata[31:STEER_W+PULSE_W+2] != '0)
                    report("tdata padding", 0, o_m_tdata[31:STEER_W+PULSE_W+2]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        logic [IN_W-1:0] va, vb, vc, vd;
        t_result neutral;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        neutral = cmd(0, RST_PULSE_CENTER, DIR_STRAIGHT, 1'b1, 1'b0);
        plan = '{
            // calibration: reference ends at (0 + 262140 + 8 * 80000) / 10
            reading('0, '0, '0, '0, 1'b1, neutral),
            reading('1, '1, '1, '1, 1'b1, neutral),
            reading(20000, 20000, 20000, 20000, 1'b1, neutral),
            reading(20000, 20000, 20000, 20000, 1'b1, neutral),
            reading(20000, 20000, 20000, 20000, 1'b1, neutral),
            reading(20000, 20000, 20000, 20000, 1'b1, neutral),
            reading(20000, 20000, 20000, 20000, 1'b1, neutral),
            reading(20000, 20000, 20000, 20000, 1'b1, neutral),
            reading(20000, 20000, 20000, 20000, 1'b1, neutral),
            reading(20000, 20000, 20000, 20000, 1'b1, neutral),
            // balanced full scale: straight
            reading('1, '1, '1, '1, 1'b1,
                    cmd(0, RST_PULSE_CENTER, DIR_STRAIGHT, 1'b0, 1'b0)),
            reading(0, 0, 20000, 20000),
            reading(30000, 30000, 0, 0),
            // difference equal to the dead band stays straight
            reading(0, 0, 10, 0, 1'b1,
                    cmd(0, RST_PULSE_CENTER, DIR_STRAIGHT, 1'b0, 1'b0)),
            reading(0, 0, 11, 0),
            reading(11, 0, 0, 0),
            // brighter than the reference: negative magnitude
            reading(0, 0, '1, '1),
            reading('1, '1, 0, 0),
            reg_write(CFG_GAIN, '1),
            reg_write(CFG_STEER_LIMIT, 50),
            reading(0, 0, 0, 1000),
            // limit above the ceiling acts as the ceiling
            reg_write(CFG_STEER_LIMIT, 511),
            reading(0, 0, 0, 1000),
            // center below range: pulse saturates at zero
            reg_write(CFG_PULSE_CENTER, 0),
            reading(1000, 0, 0, 0, 1'b1, cmd(-500, 0, DIR_RIGHT, 1'b0, 1'b0)),
            reg_write(CFG_OFF_COURSE, '1),
            reading(0, 0, 0, 1000, 1'b1, cmd(0, 0, DIR_LEFT, 1'b0, 1'b1)),
            // zero span is a range error too
            reg_write(CFG_OFF_COURSE, 90214),
            reading(1000, 0, 0, 0, 1'b1, cmd(0, 0, DIR_RIGHT, 1'b0, 1'b1)),
            reg_write(CFG_FIRST_UNUSED, '1),
            reg_write(CFG_LAST_UNUSED, '1),
            reg_write(CFG_DEAD_BAND, 16'hFFFF),
            reg_write(CFG_OFF_COURSE, 0),
            reg_write(CFG_PULSE_CENTER, 16383),
            reg_write(CFG_GAIN, 0),
            reading(0, 0, '1, 0, 1'b1, cmd(0, 16383, DIR_STRAIGHT, 1'b0, 1'b0)),
            reading(0, 0, '1, '1),
            reg_write(CFG_STEER_LIMIT, 0),
            reg_write(CFG_DEAD_BAND, 0),
            reg_write(CFG_GAIN, 1023),
            reg_write(CFG_PULSE_CENTER, 500),
            reading(1, 0, 0, 0)
        };

        foreach (plan[k]) begin
            if (plan[k].is_reg) begin
                drain();
                write_reg(plan[k].idx, plan[k].val);
            end else begin
                send_reading(plan[k].ca, plan[k].cb, plan[k].cc, plan[k].cd,
                             plan[k].typed, plan[k].want);
            end
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            drain();
            if (ph >= NUM_PHASES - 2)
                idle_pct = 0;
            else
                case ($urandom_range(0, 2))
                    0:       idle_pct = 0;
                    1:       idle_pct = 10;
                    default: idle_pct = 35;
                endcase
            shuffle_settings();
            if (ph == 2)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                va = pick_clear();
                vb = pick_clear();
                vc = pick_clear();
                vd = pick_clear();
                // lean one side dark to get both turn directions
                case ($urandom_range(0, 2))
                    0: begin
                        va = va >> 4;
                        vb = vb >> 4;
                    end
                    1: begin
                        vc = vc >> 4;
                        vd = vd >> 4;
                    end
                    default: ;
                endcase
                send_reading(va, vb, vc, vd, 1'b0, '0);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
